[rtl/bbs_pkg.sv]
`default_nettype none

package bbs_pkg;

  localparam int WINDOW_MAX_DEF = 64;
  localparam int PRICE_BITS_DEF = 24;

  localparam int ID_W       = 16;
  localparam int LEN_REG_W  = 7;
  localparam int K_W        = 12;
  localparam int K_FRAC     = 8;
  localparam int MEAN_W     = 24;
  localparam int BAND_W     = 29;
  localparam int SIG_W      = 2;
  localparam int OFF_W      = 30;
  localparam int EXT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WATCHED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_K  = 2'd2;

  localparam logic [ID_W-1:0]      ID_RESET  = 16'd0;
  localparam logic [LEN_REG_W-1:0] LEN_RESET = 7'd20;
  localparam logic [K_W-1:0]       K_RESET   = 12'd512;

  localparam logic [SIG_W-1:0] SIG_NONE = 2'd0;
  localparam logic [SIG_W-1:0] SIG_BUY  = 2'd1;
  localparam logic [SIG_W-1:0] SIG_SELL = 2'd2;

  localparam logic [OFF_W-1:0]        OFF_MAX  = 30'h3FFF_FFFF;
  localparam logic signed [EXT_W-1:0] BAND_MAX = 32'sd268435455;
  localparam logic signed [EXT_W-1:0] BAND_MIN = -32'sd268435456;

endpackage

`default_nettype wire

[rtl/bbs_ram.sv]
`default_nettype none

module bbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/bbs_fifo.sv]
`default_nettype none

module bbs_fifo #(
  parameter int WIDTH = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  full,
  output logic                  empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/bbs_front.sv]
`default_nettype none

module bbs_front
  import bbs_pkg::*;
#(
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  wire logic                  sample_valid,
  input  wire logic [ID_W-1:0]       instrument_id,
  input  wire logic [PRICE_BITS-1:0] price,
  input  wire logic [ID_W-1:0]       watched,
  input  wire logic                  queue_full,
  output logic                       sample_stall,
  output logic                       push,
  output logic      [PRICE_BITS-1:0] push_data
);

  logic accept;
  logic match;

  // Samples of other instruments are taken and dropped here.
  assign sample_stall = queue_full;
  assign accept       = sample_valid && !queue_full;
  assign match        = (instrument_id == watched);
  assign push         = accept && match;
  assign push_data    = price;

endmodule

`default_nettype wire

[rtl/bbs_back.sv]
`default_nettype none

module bbs_back
  import bbs_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [$clog2(WINDOW_MAX+1)-1:0]    n,
  input  wire logic [K_W-1:0]                     band_k,
  input  wire logic                               clear,
  input  wire logic                               queue_empty,
  input  wire logic [PRICE_BITS-1:0]              queue_data,
  output logic                                    queue_pop,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output logic                                    window_full,
  output logic      [SIG_W-1:0]                   signal,
  output logic                                    holding,
  output logic      [MEAN_W-1:0]                  mean_price,
  output logic signed [BAND_W-1:0]                upper_band,
  output logic signed [BAND_W-1:0]                lower_band
);

  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int SLOT_W = $clog2(WINDOW_MAX);
  localparam int SUM_W  = PRICE_BITS + SLOT_W;
  localparam int SQ_W   = 2 * PRICE_BITS + SLOT_W;
  localparam int D_W    = SQ_W + SLOT_W;
  localparam int ROOT_W = D_W / 2;
  localparam int KP_W   = K_W + ROOT_W;
  localparam int OFFD_W = KP_W - K_FRAC;
  localparam int DIV_W  = (SUM_W > OFFD_W) ? SUM_W : OFFD_W;
  localparam int DIV_R  = 4;
  localparam int DIV_IT = (DIV_W + DIV_R - 1) / DIV_R;
  localparam int DIV_PW = DIV_IT * DIV_R;
  localparam int DCNT_W = $clog2(DIV_IT + 1);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_READ   = 11'b000_0000_0010,
    ST_UPDATE = 11'b000_0000_0100,
    ST_MULT   = 11'b000_0000_1000,
    ST_DIFF   = 11'b000_0001_0000,
    ST_ROOT   = 11'b000_0010_0000,
    ST_KMUL   = 11'b000_0100_0000,
    ST_KLOAD  = 11'b000_1000_0000,
    ST_OFFDIV = 11'b001_0000_0000,
    ST_BAND   = 11'b010_0000_0000,
    ST_SIG    = 11'b100_0000_0000
  } state_t;

  state_t                  state;
  logic [PRICE_BITS-1:0]   price_q;
  logic [PRICE_BITS-1:0]   old_q;
  logic [2*PRICE_BITS-1:0] old_sq;
  logic [2*PRICE_BITS-1:0] new_sq;
  logic [LEN_W-1:0]        fill_count;
  logic [SLOT_W-1:0]       write_slot;
  logic [SUM_W-1:0]        window_sum;
  logic [SQ_W-1:0]         window_sum_squares;
  logic                    holding_flag;
  logic                    full_q;
  logic [D_W-1:0]          nsq;
  logic [D_W-1:0]          ssq;
  logic [D_W-1:0]          sq_val;
  logic [D_W-1:0]          sq_res;
  logic [D_W-1:0]          sq_bit;
  logic [DIV_PW-1:0]       div_q;
  logic [LEN_W-1:0]        div_rem;
  logic [DCNT_W-1:0]       div_cnt;
  logic [PRICE_BITS-1:0]   mean_full;
  logic [KP_W-1:0]         kp;
  logic [OFF_W-1:0]        off;
  logic [BAND_W-1:0]       up_q;
  logic [BAND_W-1:0]       lo_q;

  logic [PRICE_BITS-1:0]   ram_rdata;
  logic                    ram_we;

  logic [2*PRICE_BITS-1:0]   rd_sq_w;
  logic [2*PRICE_BITS-1:0]   new_sq_w;
  logic                      replace;
  logic [SUM_W-1:0]          sum_next;
  logic [SQ_W-1:0]           sumsq_next;
  logic [LEN_W-1:0]          fill_next;
  logic [LEN_W-1:0]          slot_inc;
  logic [SLOT_W-1:0]         slot_next;
  logic                      full_next;
  logic [LEN_W+SQ_W-1:0]     nsq_full;
  logic [D_W-1:0]            ssq_full;
  logic [D_W-1:0]            sq_trial;
  logic                      sq_ge;
  logic [D_W-1:0]            sq_val_next;
  logic [D_W-1:0]            sq_res_next;
  logic [DIV_PW-1:0]         div_q_next;
  logic [LEN_W-1:0]          div_rem_next;
  logic [KP_W-1:0]           kp_w;
  logic [DIV_PW+OFF_W-1:0]   quot_ext;
  logic [OFF_W-1:0]          off_w;
  logic signed [EXT_W-1:0]   mean_s;
  logic signed [EXT_W-1:0]   off_s;
  logic signed [EXT_W-1:0]   up_raw;
  logic signed [EXT_W-1:0]   lo_raw;
  logic signed [EXT_W-1:0]   up_sat;
  logic signed [EXT_W-1:0]   lo_sat;
  logic signed [EXT_W-1:0]   price_s;
  logic signed [EXT_W-1:0]   up_s;
  logic signed [EXT_W-1:0]   lo_s;
  logic                      buy;
  logic                      sell;
  logic                      out_free;
  logic [PRICE_BITS+MEAN_W-1:0] mean_ext;

  assign queue_pop = (state == ST_IDLE) && !queue_empty;
  assign ram_we    = (state == ST_READ);

  bbs_ram #(
    .WIDTH (PRICE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata (price_q),
    .re    (queue_pop),
    .raddr (write_slot),
    .rdata (ram_rdata)
  );

  assign rd_sq_w  = ram_rdata * ram_rdata;
  assign new_sq_w = price_q * price_q;

  assign replace    = (fill_count >= n);
  assign sum_next   = window_sum - (replace ? SUM_W'(old_q) : '0) + SUM_W'(price_q);
  assign sumsq_next = window_sum_squares - (replace ? SQ_W'(old_sq) : '0) + SQ_W'(new_sq);
  assign fill_next  = replace ? fill_count : fill_count + 1'b1;
  assign slot_inc   = LEN_W'(write_slot) + 1'b1;
  assign slot_next  = (slot_inc >= n) ? '0 : SLOT_W'(slot_inc);
  assign full_next  = (fill_next >= n);

  assign nsq_full = n * window_sum_squares;
  assign ssq_full = window_sum * window_sum;

  assign sq_trial    = sq_res + sq_bit;
  assign sq_ge       = (sq_val >= sq_trial);
  assign sq_val_next = sq_ge ? sq_val - sq_trial : sq_val;
  assign sq_res_next = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;

  always_comb begin
    logic [DIV_PW-1:0] q;
    logic [LEN_W-1:0]  r;
    logic [LEN_W:0]    t;
    logic              qb;
    q = div_q;
    r = div_rem;
    for (int i = 0; i < DIV_R; i++) begin
      t = {r, q[DIV_PW-1]};
      qb = (t >= {1'b0, n});
      if (qb) begin
        r = LEN_W'(t - {1'b0, n});
      end else begin
        r = t[LEN_W-1:0];
      end
      q = {q[DIV_PW-2:0], qb};
    end
    div_q_next   = q;
    div_rem_next = r;
  end

  assign kp_w     = band_k * sq_res[ROOT_W-1:0];
  assign quot_ext = {{OFF_W{1'b0}}, div_q};
  assign off_w    = (quot_ext > {{DIV_PW{1'b0}}, OFF_MAX}) ? OFF_MAX : quot_ext[OFF_W-1:0];

  assign mean_s = {{(EXT_W-PRICE_BITS){1'b0}}, mean_full};
  assign off_s  = {{(EXT_W-OFF_W){1'b0}}, off};
  assign up_raw = mean_s + off_s;
  assign lo_raw = mean_s - off_s;
  assign up_sat = (up_raw > BAND_MAX) ? BAND_MAX : ((up_raw < BAND_MIN) ? BAND_MIN : up_raw);
  assign lo_sat = (lo_raw > BAND_MAX) ? BAND_MAX : ((lo_raw < BAND_MIN) ? BAND_MIN : lo_raw);

  assign price_s = {{(EXT_W-PRICE_BITS){1'b0}}, price_q};
  assign up_s    = {{(EXT_W-BAND_W){up_q[BAND_W-1]}}, up_q};
  assign lo_s    = {{(EXT_W-BAND_W){lo_q[BAND_W-1]}}, lo_q};
  assign buy     = full_q && (price_s < lo_s) && !holding_flag;
  assign sell    = full_q && !buy && (price_s > up_s) && holding_flag;

  assign out_free = !result_valid || !result_stall;
  assign mean_ext = {{MEAN_W{1'b0}}, mean_full};

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      fill_count         <= '0;
      write_slot         <= '0;
      window_sum         <= '0;
      window_sum_squares <= '0;
      holding_flag       <= 1'b0;
      result_valid       <= 1'b0;
    end else begin
      if ((state == ST_SIG) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (clear) begin
        fill_count         <= '0;
        write_slot         <= '0;
        window_sum         <= '0;
        window_sum_squares <= '0;
      end else if (state == ST_UPDATE) begin
        fill_count         <= fill_next;
        write_slot         <= slot_next;
        window_sum         <= sum_next;
        window_sum_squares <= sumsq_next;
      end
      unique case (state)
        ST_IDLE: begin
          if (!queue_empty) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          state <= full_next ? ST_MULT : ST_SIG;
        end
        ST_MULT: begin
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (sq_bit == '0 && div_cnt == '0) begin
            state <= ST_KMUL;
          end
        end
        ST_KMUL: begin
          state <= ST_KLOAD;
        end
        ST_KLOAD: begin
          state <= ST_OFFDIV;
        end
        ST_OFFDIV: begin
          if (div_cnt == '0) begin
            state <= ST_BAND;
          end
        end
        ST_BAND: begin
          state <= ST_SIG;
        end
        ST_SIG: begin
          if (out_free) begin
            if (buy) begin
              holding_flag <= 1'b1;
            end else if (sell) begin
              holding_flag <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        price_q <= queue_data;
      end
      ST_READ: begin
        old_q  <= ram_rdata;
        old_sq <= rd_sq_w;
        new_sq <= new_sq_w;
      end
      ST_UPDATE: begin
        full_q    <= full_next;
        mean_full <= '0;
        up_q      <= '0;
        lo_q      <= '0;
      end
      ST_MULT: begin
        nsq     <= nsq_full[D_W-1:0];
        ssq     <= ssq_full;
        div_q   <= DIV_PW'(window_sum);
        div_rem <= '0;
        div_cnt <= DCNT_W'(DIV_IT);
      end
      ST_DIFF: begin
        sq_val <= nsq - ssq;
        sq_res <= '0;
        sq_bit <= {2'b01, {(D_W-2){1'b0}}};
      end
      ST_ROOT: begin
        if (sq_bit != '0) begin
          sq_val <= sq_val_next;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
        end
        if (div_cnt != '0) begin
          div_q   <= div_q_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt - 1'b1;
        end else begin
          mean_full <= div_q[PRICE_BITS-1:0];
        end
      end
      ST_KMUL: begin
        kp <= kp_w;
      end
      ST_KLOAD: begin
        div_q   <= DIV_PW'(kp[KP_W-1:K_FRAC]);
        div_rem <= '0;
        div_cnt <= DCNT_W'(DIV_IT);
      end
      ST_OFFDIV: begin
        if (div_cnt != '0) begin
          div_q   <= div_q_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt - 1'b1;
        end else begin
          off <= off_w;
        end
      end
      ST_BAND: begin
        up_q <= up_sat[BAND_W-1:0];
        lo_q <= lo_sat[BAND_W-1:0];
      end
      ST_SIG: begin
        if (out_free) begin
          window_full <= full_q;
          signal      <= buy ? SIG_BUY : (sell ? SIG_SELL : SIG_NONE);
          holding     <= buy ? 1'b1 : (sell ? 1'b0 : holding_flag);
          mean_price  <= mean_ext[MEAN_W-1:0];
          upper_band  <= up_q;
          lower_band  <= lo_q;
        end
      end
      default: begin
      end
    endcase
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= n)
    else $error("fill count above window length");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    LEN_W'(write_slot) < n)
    else $error("write slot outside window");

  a_signal_needs_full: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (window_full || signal == SIG_NONE))
    else $error("trade signal before window is full");

  a_buy_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && signal == SIG_BUY) |-> holding)
    else $error("buy without position");

  a_sell_releases: assert property (@(posedge clk) disable iff (rst)
    (result_valid && signal == SIG_SELL) |-> !holding)
    else $error("sell left position open");

endmodule

`default_nettype wire

[rtl/bollinger_band_signal.sv]
// Channel   Handshake                  Payload
// sample    sample_valid/sample_stall  instrument_id, price
// result    result_valid/result_stall  window_full, signal, holding, mean_price,
//                                      upper_band, lower_band
// cfg       cfg_valid/cfg_ready        cfg_index, cfg_data
//
// A sample for another instrument is dropped and gives no word.
// A watched sample goes through read, update and signal while the window fills;
// once full, it adds the bit-per-cycle square root and radix-16 divider steps.
// A two-word queue lets samples be taken while the back end works or stalls.
// Reset is synchronous; the window memory needs no clearing pass.
`default_nettype none

module bollinger_band_signal
  import bbs_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   sample_valid,
  output logic                        sample_stall,
  input  wire logic [ID_W-1:0]        instrument_id,
  input  wire logic [PRICE_BITS-1:0]  price,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic                        window_full,
  output logic      [SIG_W-1:0]       signal,
  output logic                        holding,
  output logic      [MEAN_W-1:0]      mean_price,
  output logic signed [BAND_W-1:0]    upper_band,
  output logic signed [BAND_W-1:0]    lower_band,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);

  logic [ID_W-1:0]         watched_instrument;
  logic [LEN_REG_W-1:0]    window_length;
  logic [K_W-1:0]          band_width_k;
  logic                    clear;
  logic [LEN_W+LEN_REG_W-1:0] len_ext;
  logic [LEN_W-1:0]        n;
  logic                    cfg_write;
  logic                    push;
  logic [PRICE_BITS-1:0]   push_data;
  logic                    queue_full;
  logic                    queue_empty;
  logic                    queue_pop;
  logic [PRICE_BITS-1:0]   queue_data;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // The window is cleared at the same edge that takes the new length.
  assign clear = cfg_write && (cfg_index == REG_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      watched_instrument <= ID_RESET;
      window_length      <= LEN_RESET;
      band_width_k       <= K_RESET;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_WATCHED: watched_instrument <= cfg_data[ID_W-1:0];
          REG_LENGTH:  window_length <= cfg_data[LEN_REG_W-1:0];
          REG_BAND_K:  band_width_k <= cfg_data[K_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // The window length is held between one and the memory depth.
  assign len_ext = {{LEN_W{1'b0}}, window_length};
  always_comb begin
    priority if (window_length == '0) begin
      n = LEN_W'(1);
    end else if (len_ext > (LEN_W+LEN_REG_W)'(WINDOW_MAX)) begin
      n = LEN_W'(WINDOW_MAX);
    end else begin
      n = len_ext[LEN_W-1:0];
    end
  end

  bbs_front #(
    .PRICE_BITS (PRICE_BITS)
  ) u_front (
    .sample_valid  (sample_valid),
    .instrument_id (instrument_id),
    .price         (price),
    .watched       (watched_instrument),
    .queue_full    (queue_full),
    .sample_stall  (sample_stall),
    .push          (push),
    .push_data     (push_data)
  );

  bbs_fifo #(
    .WIDTH (PRICE_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (queue_pop),
    .pop_data  (queue_data),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  bbs_back #(
    .WINDOW_MAX (WINDOW_MAX),
    .PRICE_BITS (PRICE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .n            (n),
    .band_k       (band_width_k),
    .clear        (clear),
    .queue_empty  (queue_empty),
    .queue_data   (queue_data),
    .queue_pop    (queue_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .window_full  (window_full),
    .signal       (signal),
    .holding      (holding),
    .mean_price   (mean_price),
    .upper_band   (upper_band),
    .lower_band   (lower_band)
  );

endmodule

`default_nettype wire
